// ===== sv/hpb_pkg.sv =====
// Shared types, constants and command codes for the ramped PID heater controller
package hpb_pkg;

    localparam logic [7:0]  HPB_DRIVE_MAX   = 8'd255;
    localparam logic [31:0] HPB_MAX_ON_MS   = 32'd30000;
    localparam logic [31:0] HPB_MIN_OFF_MS  = 32'd5000;
    localparam logic [7:0]  HPB_DRIVE_FLOOR = 8'd10;
    localparam logic [10:0] HPB_DT_DEFAULT  = 11'd100;
    localparam logic [15:0] HPB_DT_MAX      = 16'd2000;
    localparam logic [10:0] HPB_MS_PER_S    = 11'd1000;
    localparam logic [8:0]  HPB_ALPHA_ONE   = 9'd256;
    localparam logic [24:0] HPB_RCP_125     = 25'd17179870;

    localparam int HPB_DIV_W   = 42;
    localparam int HPB_DVS_W   = 11;
    localparam int HPB_ERR_W   = 18;
    localparam int HPB_RAW_W   = 29;
    localparam int HPB_INT_W   = 28;
    localparam int HPB_MA_W    = 30;
    localparam int HPB_MB_W    = 17;
    localparam int HPB_PROD_W  = 47;
    localparam int HPB_ACC_W   = 48;
    localparam int HPB_TOT_W   = 58;

    localparam logic signed [15:0] HPB_RST_TARGET = 16'sd5120;
    localparam logic [15:0] HPB_RST_RAMP     = 16'd256;
    localparam logic [14:0] HPB_RST_BAND     = 15'd512;
    localparam logic [15:0] HPB_RST_ILIMIT   = 16'd2560;
    localparam logic [15:0] HPB_RST_GP       = 16'd2560;
    localparam logic [15:0] HPB_RST_GI       = 16'd256;
    localparam logic [15:0] HPB_RST_GD       = 16'd256;
    localparam logic [8:0]  HPB_RST_ALPHA    = 9'd128;

    typedef enum logic [2:0] {
        CFG_TARGET = 3'd0,
        CFG_RAMP   = 3'd1,
        CFG_BAND   = 3'd2,
        CFG_ILIMIT = 3'd3,
        CFG_GP     = 3'd4,
        CFG_GI     = 3'd5,
        CFG_GD     = 3'd6,
        CFG_ALPHA  = 3'd7
    } hpb_cfg_idx_t;

    typedef struct packed {
        logic [15:0]        elapsed_ms;
        logic signed [15:0] temp_a;
        logic signed [15:0] temp_b;
    } hpb_in_t;

    typedef struct packed {
        logic [7:0]         drive_level;
        logic               cooling_hold;
        logic signed [15:0] active_setpoint;
    } hpb_out_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_COOL, OP_MUL_STEP, OP_DIV_STEP, OP_SETPT, OP_ERR,
        OP_BANG, OP_MUL_I, OP_INTEG, OP_DIV_SLOPE, OP_RAW, OP_MUL_A, OP_MUL_B,
        OP_FILT, OP_MUL_P, OP_MUL_D, OP_SUM_PD, OP_MUL_G, OP_TOTAL, OP_DIV_TOT,
        OP_CLAMP, OP_ONTIME, OP_EMIT
    } hpb_op_t;

    typedef struct packed {
        hpb_op_t op;
    } hpb_cmd_t;

    typedef struct packed {
        logic div_done;
        logic cool_stay;
        logic in_band;
        logic out_free;
    } hpb_status_t;

endpackage

// ===== sv/heater_ramped_pid_bangbang_unit.sv =====
// Ramped-setpoint heater controller: bang-bang outside the band, PID inside
// In the PID band the processing time is set mostly by the bit-serial slope divide by dt;
// outside the band the tick skips the PID steps, and in a cooling hold it goes straight to the result.
// Ticks run one at a time: a new word is taken only once the last tick has reached its result;
// the next word is taken while the last result waits.
// Reset (aresetn low, synchronous): registers to defaults, setpoint to 20 degC,
// integral, slope and timers cleared, heating phase.
module heater_ramped_pid_bangbang_unit import hpb_pkg::*; #(
    parameter logic [7:0]  DRIVE_MAX  = HPB_DRIVE_MAX,
    parameter logic [31:0] MAX_ON_MS  = HPB_MAX_ON_MS,
    parameter logic [31:0] MIN_OFF_MS = HPB_MIN_OFF_MS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  hpb_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output hpb_out_t    m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    hpb_cmd_t    cmd;
    hpb_status_t status;

    hpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hpb_dp #(
        .DRIVE_MAX  (DRIVE_MAX),
        .MAX_ON_MS  (MAX_ON_MS),
        .MIN_OFF_MS (MIN_OFF_MS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );
endmodule

// ===== sv/hpb_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle
module hpb_div import hpb_pkg::*; #(
    parameter int W   = HPB_DIV_W,
    parameter int DVW = HPB_DVS_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   dividend,
    input  logic [DVW-1:0] divisor,
    output logic [W-1:0]   quot,
    output logic           rem_nz,
    output logic           done
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]   q_reg;
    logic [DVW-1:0] r_reg;
    logic [DVW-1:0] d_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DVW:0]   trial;
    logic           fits;

    assign trial = {r_reg, q_reg[W-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[W-2:0], fits};
            r_reg <= fits ? DVW'(trial - {1'b0, d_reg}) : trial[DVW-1:0];
        end
    end

    assign quot   = q_reg;
    assign rem_nz = r_reg != '0;
    assign done   = done_reg;
endmodule

// ===== sv/hpb_ctrl.sv =====
// Sequencer that steps the datapath through one control tick
module hpb_ctrl import hpb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  hpb_status_t status,
    output hpb_cmd_t    cmd
);
    typedef enum logic [25:0] {
        S_IDLE       = 26'h0000001,
        S_COOL       = 26'h0000002,
        S_MUL_STEP   = 26'h0000004,
        S_DIV_STEP   = 26'h0000008,
        S_WAIT_STEP  = 26'h0000010,
        S_SETPT      = 26'h0000020,
        S_ERR        = 26'h0000040,
        S_BAND       = 26'h0000080,
        S_MUL_I      = 26'h0000100,
        S_INTEG      = 26'h0000200,
        S_DIV_SLOPE  = 26'h0000400,
        S_WAIT_SLOPE = 26'h0000800,
        S_RAW        = 26'h0001000,
        S_MUL_A      = 26'h0002000,
        S_MUL_B      = 26'h0004000,
        S_FILT       = 26'h0008000,
        S_MUL_P      = 26'h0010000,
        S_MUL_D      = 26'h0020000,
        S_SUM_PD     = 26'h0040000,
        S_MUL_G      = 26'h0080000,
        S_TOTAL      = 26'h0100000,
        S_DIV_TOT    = 26'h0200000,
        S_WAIT_TOT   = 26'h0400000,
        S_CLAMP      = 26'h0800000,
        S_ONTIME     = 26'h1000000,
        S_EMIT       = 26'h2000000
    } hpb_state_t;

    hpb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_COOL;
                end
            end
            S_COOL: begin
                cmd.op     = OP_COOL;
                state_next = status.cool_stay ? S_EMIT : S_MUL_STEP;
            end
            S_MUL_STEP: begin
                cmd.op     = OP_MUL_STEP;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                cmd.op     = OP_DIV_STEP;
                state_next = S_WAIT_STEP;
            end
            S_WAIT_STEP: begin
                if (status.div_done) begin
                    state_next = S_SETPT;
                end
            end
            S_SETPT: begin
                cmd.op     = OP_SETPT;
                state_next = S_ERR;
            end
            S_ERR: begin
                cmd.op     = OP_ERR;
                state_next = S_BAND;
            end
            S_BAND: begin
                cmd.op     = OP_BANG;
                state_next = status.in_band ? S_MUL_I : S_ONTIME;
            end
            S_MUL_I: begin
                cmd.op     = OP_MUL_I;
                state_next = S_INTEG;
            end
            S_INTEG: begin
                cmd.op     = OP_INTEG;
                state_next = S_DIV_SLOPE;
            end
            S_DIV_SLOPE: begin
                cmd.op     = OP_DIV_SLOPE;
                state_next = S_WAIT_SLOPE;
            end
            S_WAIT_SLOPE: begin
                if (status.div_done) begin
                    state_next = S_RAW;
                end
            end
            S_RAW: begin
                cmd.op     = OP_RAW;
                state_next = S_MUL_A;
            end
            S_MUL_A: begin
                cmd.op     = OP_MUL_A;
                state_next = S_MUL_B;
            end
            S_MUL_B: begin
                cmd.op     = OP_MUL_B;
                state_next = S_FILT;
            end
            S_FILT: begin
                cmd.op     = OP_FILT;
                state_next = S_MUL_P;
            end
            S_MUL_P: begin
                cmd.op     = OP_MUL_P;
                state_next = S_MUL_D;
            end
            S_MUL_D: begin
                cmd.op     = OP_MUL_D;
                state_next = S_SUM_PD;
            end
            S_SUM_PD: begin
                cmd.op     = OP_SUM_PD;
                state_next = S_MUL_G;
            end
            S_MUL_G: begin
                cmd.op     = OP_MUL_G;
                state_next = S_TOTAL;
            end
            S_TOTAL: begin
                cmd.op     = OP_TOTAL;
                state_next = S_DIV_TOT;
            end
            S_DIV_TOT: begin
                cmd.op     = OP_DIV_TOT;
                state_next = S_WAIT_TOT;
            end
            S_WAIT_TOT: begin
                if (status.div_done) begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP: begin
                cmd.op     = OP_CLAMP;
                state_next = S_ONTIME;
            end
            S_ONTIME: begin
                cmd.op     = OP_ONTIME;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== sv/hpb_dp.sv =====
// Datapath: configuration, controller state, shared multiplier, slope divider, result register
module hpb_dp import hpb_pkg::*; #(
    parameter logic [7:0]  DRIVE_MAX  = HPB_DRIVE_MAX,
    parameter logic [31:0] MAX_ON_MS  = HPB_MAX_ON_MS,
    parameter logic [31:0] MIN_OFF_MS = HPB_MIN_OFF_MS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  hpb_cmd_t    cmd,
    output hpb_status_t status,
    input  hpb_in_t     s_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output logic        m_valid,
    input  logic        m_ready,
    output hpb_out_t    m_data
);
    logic signed [15:0] target_reg;
    logic [15:0] ramp_reg, ilimit_reg, gp_reg, gi_reg, gd_reg;
    logic [14:0] band_reg;
    logic [8:0]  alpha_reg;

    logic signed [15:0]          sp_reg;
    logic signed [HPB_INT_W-1:0] integ_reg;
    logic signed [HPB_ERR_W-1:0] prev_reg;
    logic signed [HPB_RAW_W-1:0] filt_reg;
    logic        phase_reg;
    logic [31:0] cool_reg, on_reg;

    logic [15:0]        el_reg;
    logic signed [15:0] ta_reg, tb_reg;
    logic [10:0]        dt_reg;
    logic signed [HPB_ERR_W-1:0]  err_reg;
    logic signed [HPB_RAW_W-1:0]  raw_reg;
    logic signed [HPB_PROD_W-1:0] prod_reg;
    logic signed [HPB_ACC_W-1:0]  acc_reg;
    logic signed [HPB_TOT_W-1:0]  tot_reg;
    logic        neg_reg;
    logic [7:0]  drive_reg;
    logic        m_valid_reg;
    hpb_out_t    m_data_reg;
    logic [17:0] kq_reg;
    logic        kq_done_reg;

    logic signed [HPB_MA_W-1:0]   mul_a;
    logic signed [HPB_MB_W-1:0]   mul_b;
    logic                         div_start;
    logic [HPB_DIV_W-1:0]         div_num;
    logic [HPB_DVS_W-1:0]         div_den;
    logic [HPB_DIV_W-1:0]         div_q;
    logic                         div_nz;
    logic                         div_done;

    logic [32:0] cool_sum, on_sum;
    logic [31:0] cool_sat, on_sat;
    logic [10:0] dt_in;
    logic [8:0]  alpha_sat;
    logic signed [19:0] sp_w, step_w, tgt_w;
    logic signed [16:0] temp_sum;
    logic signed [HPB_ERR_W-1:0] err_new, band_w;
    logic signed [30:0] integ_sum, lim_w;
    logic signed [18:0] diff;
    logic [17:0]        diff_mag;
    logic [27:0]        slope_num;
    logic signed [HPB_ACC_W-1:0] filt_sum;
    logic signed [HPB_TOT_W-1:0] acc_w, tot_new, tot_mag;
    logic [HPB_DIV_W-1:0]        q_tot;
    logic [26:0]                 kdiv_num;
    logic [48:0]                 kdiv_prod;

    hpb_div #(.W(HPB_DIV_W), .DVW(HPB_DVS_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quot     (div_q),
        .rem_nz   (div_nz),
        .done     (div_done)
    );

    assign dt_in = (s_data.elapsed_ms == 16'd0 || s_data.elapsed_ms > HPB_DT_MAX)
                 ? HPB_DT_DEFAULT : s_data.elapsed_ms[10:0];
    assign alpha_sat = (alpha_reg > HPB_ALPHA_ONE) ? HPB_ALPHA_ONE : alpha_reg;

    assign cool_sum = {1'b0, cool_reg} + {17'd0, el_reg};
    assign cool_sat = cool_sum[32] ? 32'hFFFF_FFFF : cool_sum[31:0];
    assign on_sum   = {1'b0, on_reg} + {22'd0, dt_reg};
    assign on_sat   = on_sum[32] ? 32'hFFFF_FFFF : on_sum[31:0];

    assign sp_w   = 20'(sp_reg);
    assign step_w = {2'b00, kq_reg};
    assign tgt_w  = 20'(target_reg);

    assign temp_sum = 17'(ta_reg) + 17'(tb_reg);
    assign err_new  = HPB_ERR_W'(sp_reg) - HPB_ERR_W'(temp_sum >>> 1);
    assign band_w   = HPB_ERR_W'({1'b0, band_reg});

    assign integ_sum = 31'(integ_reg) + 31'(prod_reg);
    assign lim_w     = 31'({ilimit_reg, 10'd0}) - 31'({ilimit_reg, 4'd0})
                     - 31'({ilimit_reg, 3'd0});

    assign diff      = 19'(err_reg) - 19'(prev_reg);
    assign diff_mag  = diff[18] ? 18'(-diff) : diff[17:0];
    assign slope_num = {diff_mag, 10'd0} - 28'({diff_mag, 4'd0}) - 28'({diff_mag, 3'd0});

    assign filt_sum = acc_reg + HPB_ACC_W'(prod_reg);

    assign acc_w   = HPB_TOT_W'(acc_reg);
    assign tot_new = (acc_w <<< 10) - (acc_w <<< 4) - (acc_w <<< 3) + HPB_TOT_W'(prod_reg);
    assign tot_mag = tot_reg[HPB_TOT_W-1] ? -tot_reg : tot_reg;
    assign q_tot   = HPB_DIV_W'(kq_reg);

    assign kdiv_num  = (cmd.op == OP_DIV_TOT)
                     ? ((|tot_mag[HPB_TOT_W-1:43]) ? '1 : tot_mag[42:16])
                     : prod_reg[26:0];
    assign kdiv_prod = 49'(kdiv_num[26:3]) * 49'(HPB_RCP_125);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_STEP: begin
                mul_a = HPB_MA_W'({1'b0, ramp_reg});
                mul_b = HPB_MB_W'({1'b0, dt_reg});
            end
            OP_MUL_I: begin
                mul_a = HPB_MA_W'(err_reg);
                mul_b = HPB_MB_W'({1'b0, dt_reg});
            end
            OP_MUL_A: begin
                mul_a = HPB_MA_W'(raw_reg);
                mul_b = HPB_MB_W'({1'b0, alpha_sat});
            end
            OP_MUL_B: begin
                mul_a = HPB_MA_W'(filt_reg);
                mul_b = HPB_MB_W'({1'b0, HPB_ALPHA_ONE - alpha_sat});
            end
            OP_MUL_P: begin
                mul_a = HPB_MA_W'(err_reg);
                mul_b = HPB_MB_W'({1'b0, gp_reg});
            end
            OP_MUL_D: begin
                mul_a = HPB_MA_W'(filt_reg);
                mul_b = HPB_MB_W'({1'b0, gd_reg});
            end
            OP_MUL_G: begin
                mul_a = HPB_MA_W'(integ_reg);
                mul_b = HPB_MB_W'({1'b0, gi_reg});
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = HPB_MS_PER_S;
        case (cmd.op)
            OP_DIV_SLOPE: begin
                div_start = 1'b1;
                div_num   = HPB_DIV_W'(slope_num);
                div_den   = dt_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= HPB_RST_TARGET;
            ramp_reg    <= HPB_RST_RAMP;
            band_reg    <= HPB_RST_BAND;
            ilimit_reg  <= HPB_RST_ILIMIT;
            gp_reg      <= HPB_RST_GP;
            gi_reg      <= HPB_RST_GI;
            gd_reg      <= HPB_RST_GD;
            alpha_reg   <= HPB_RST_ALPHA;
        end else if (cfg_we) begin
            unique case (hpb_cfg_idx_t'(cfg_index))
                CFG_TARGET: target_reg <= cfg_wdata;
                CFG_RAMP:   ramp_reg   <= cfg_wdata;
                CFG_BAND:   band_reg   <= cfg_wdata[14:0];
                CFG_ILIMIT: ilimit_reg <= cfg_wdata;
                CFG_GP:     gp_reg     <= cfg_wdata;
                CFG_GI:     gi_reg     <= cfg_wdata;
                CFG_GD:     gd_reg     <= cfg_wdata;
                CFG_ALPHA:  alpha_reg  <= cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= HPB_RST_TARGET;
            integ_reg   <= '0;
            prev_reg    <= '0;
            filt_reg    <= '0;
            phase_reg   <= 1'b0;
            cool_reg    <= '0;
            on_reg      <= '0;
            m_valid_reg <= 1'b0;
            kq_done_reg <= 1'b0;
        end else begin
            kq_done_reg <= (cmd.op == OP_DIV_STEP) || (cmd.op == OP_DIV_TOT);
            if (cmd.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_COOL: begin
                    if (phase_reg) begin
                        cool_reg <= cool_sat;
                        if (cool_sat >= MIN_OFF_MS) begin
                            phase_reg <= 1'b0;
                            on_reg    <= '0;
                        end
                    end
                end
                OP_SETPT: begin
                    if (tgt_w > sp_w + step_w) begin
                        sp_reg <= sp_reg + 16'(kq_reg);
                    end else if (tgt_w < sp_w - step_w) begin
                        sp_reg <= sp_reg - 16'(kq_reg);
                    end else begin
                        sp_reg <= target_reg;
                    end
                end
                OP_BANG: begin
                    if (!status.in_band) begin
                        prev_reg <= err_reg;
                    end
                end
                OP_INTEG: begin
                    if (integ_sum > lim_w) begin
                        integ_reg <= HPB_INT_W'(lim_w);
                    end else if (integ_sum < -lim_w) begin
                        integ_reg <= HPB_INT_W'(-lim_w);
                    end else begin
                        integ_reg <= HPB_INT_W'(integ_sum);
                    end
                end
                OP_FILT: begin
                    filt_reg <= HPB_RAW_W'(filt_sum >>> 8);
                    prev_reg <= err_reg;
                end
                OP_ONTIME: begin
                    if (drive_reg != 8'd0) begin
                        on_reg <= on_sat;
                        if (on_sat >= MAX_ON_MS) begin
                            phase_reg <= 1'b1;
                            cool_reg  <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op) inside
            OP_LOAD: begin
                el_reg <= s_data.elapsed_ms;
                ta_reg <= s_data.temp_a;
                tb_reg <= s_data.temp_b;
                dt_reg <= dt_in;
            end
            OP_COOL: begin
                drive_reg <= 8'd0;
            end
            OP_MUL_STEP, OP_MUL_I, OP_MUL_A, OP_MUL_P, OP_MUL_G: begin
                prod_reg <= HPB_PROD_W'(mul_a * mul_b);
            end
            OP_MUL_B, OP_MUL_D: begin
                acc_reg  <= HPB_ACC_W'(prod_reg);
                prod_reg <= HPB_PROD_W'(mul_a * mul_b);
            end
            OP_DIV_STEP, OP_DIV_TOT: begin
                kq_reg <= kdiv_prod[48:31];
            end
            OP_ERR: begin
                err_reg <= err_new;
            end
            OP_BANG: begin
                drive_reg <= (err_reg > band_w) ? DRIVE_MAX : 8'd0;
            end
            OP_DIV_SLOPE: begin
                neg_reg <= diff[18];
            end
            OP_RAW: begin
                if (neg_reg) begin
                    raw_reg <= -(HPB_RAW_W'(div_q[27:0]) + HPB_RAW_W'(div_nz));
                end else begin
                    raw_reg <= HPB_RAW_W'(div_q[27:0]);
                end
            end
            OP_SUM_PD: begin
                acc_reg <= acc_reg + HPB_ACC_W'(prod_reg);
            end
            OP_TOTAL: begin
                tot_reg <= tot_new;
            end
            OP_CLAMP: begin
                if (tot_reg[HPB_TOT_W-1] && q_tot != '0) begin
                    drive_reg <= err_reg[HPB_ERR_W-1] ? HPB_DRIVE_FLOOR : 8'd0;
                end else if (err_reg[HPB_ERR_W-1] && q_tot < HPB_DIV_W'(HPB_DRIVE_FLOOR)) begin
                    drive_reg <= HPB_DRIVE_FLOOR;
                end else if (q_tot > HPB_DIV_W'(DRIVE_MAX)) begin
                    drive_reg <= DRIVE_MAX;
                end else begin
                    drive_reg <= q_tot[7:0];
                end
            end
            OP_ONTIME: begin
                if (drive_reg != 8'd0 && on_sat >= MAX_ON_MS) begin
                    drive_reg <= 8'd0;
                end
            end
            OP_EMIT: begin
                m_data_reg.drive_level     <= drive_reg;
                m_data_reg.cooling_hold    <= phase_reg;
                m_data_reg.active_setpoint <= sp_reg;
            end
            default: begin
            end
        endcase
    end

    assign status.div_done  = div_done || kq_done_reg;
    assign status.cool_stay = phase_reg && (cool_sat < MIN_OFF_MS);
    assign status.in_band   = !(err_reg > band_w) && (err_reg > -band_w);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
